[hdl/acl_pkg.sv]
// Shared types, codes and helpers for the IPv4 first-match access rule classifier.
package acl_pkg;

    localparam int NUM_RULES = 64;
    localparam int IDX_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int CNT_W     = IDX_W + 1;

    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_WRITE    = 1'b1;

    localparam logic [1:0] KIND_STD = 2'd0;
    localparam logic [1:0] KIND_EXT = 2'd1;
    localparam logic [1:0] KIND_PFX = 2'd2;

    localparam logic [1:0] ACT_DENY = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    // One stored rule; the valid bit lives in flops beside the memory.
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  action;
        logic        exact;
        logic [5:0]  len;
        logic [31:0] len_mask;
        logic [31:0] addr;
        logic [31:0] addr_wild;
        logic [31:0] mask;
        logic [31:0] mask_wild;
    } rule_t;

    // Top len bits set, saturating at 32.
    function automatic logic [31:0] netmask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) begin
            m = 32'h0;
        end else if (len >= 6'd32) begin
            m = 32'hFFFF_FFFF;
        end else begin
            m = ~(32'hFFFF_FFFF >> len[4:0]);
        end
        return m;
    endfunction

endpackage

[hdl/acl_rule_ram.sv]
// Rule memory with one write port, one registered read port and per-slot valid flops.
module acl_rule_ram
    import acl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic             wr_set,
    input  logic [IDX_W-1:0] wr_addr,
    input  rule_t            wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output rule_t            rd_data,
    output logic             rd_valid
);

    rule_t                mem [NUM_RULES];
    logic [NUM_RULES-1:0] valid_reg;
    rule_t                rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && wr_set) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // a clearing write drops only the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= wr_set;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[hdl/acl_match.sv]
// Compare unit shared by every slot of a scan: tests one rule against the query.
module acl_match
    import acl_pkg::*;
(
    input  rule_t       rule,
    input  logic        rule_valid,
    input  logic [31:0] q_addr,
    input  logic [5:0]  q_len,
    input  logic [31:0] q_mask,
    output logic        hit
);

    logic addr_ok;
    logic mask_ok;
    logic pfx_ok;
    logic kind_ok;

    always_comb begin
        addr_ok = ((q_addr & ~rule.addr_wild) == rule.addr);
        mask_ok = ((q_mask & ~rule.mask_wild) == rule.mask);
        pfx_ok  = !(rule.exact && (rule.len != q_len)) && (rule.len <= q_len) &&
                  (((q_addr ^ rule.addr) & rule.len_mask) == 32'h0);
        unique case (rule.kind)
            KIND_STD: kind_ok = addr_ok;
            KIND_EXT: kind_ok = addr_ok && mask_ok;
            KIND_PFX: kind_ok = pfx_ok;
            default:  kind_ok = 1'b0;
        endcase
        hit = rule_valid && kind_ok;
    end

endmodule

[hdl/ipv4_acl_first_match_classifier_top.sv]
// Top level of the IPv4 first-match access rule classifier: sequencer, query and result registers.
//
// A write transfer loads or clears one rule slot and answers deny, unmatched, slot 0 in the
// cycle right after it is taken. A classify transfer walks the rule slots from slot 0 upward, one
// read of the rule memory per cycle into a single compare unit, and stops at the first valid
// rule that matches, answering with its action and slot; when nothing matches it answers
// deny, unmatched, slot 0. One item is in work at a time; the input is ready again in the
// cycle after the result is taken. Writes to slots at or above NUM_RULES are dropped. Reset
// clears every slot's valid bit at once.
module ipv4_acl_first_match_classifier_top
    import acl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [5:0]  s_rule_index,
    input  logic        s_rule_valid,
    input  logic [1:0]  s_rule_kind,
    input  logic [1:0]  s_rule_action,
    input  logic [31:0] s_addr,
    input  logic [31:0] s_addr_wild,
    input  logic [31:0] s_mask,
    input  logic [31:0] s_mask_wild,
    input  logic [5:0]  s_length,
    input  logic        s_exact,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic        m_matched,
    output logic [5:0]  m_match_slot
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]  pipe_slot_reg, pipe_slot_next;
    logic [31:0]       q_addr_reg;
    logic [5:0]        q_len_reg;
    logic [31:0]       q_mask_reg;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_action_reg, m_action_next;
    logic              m_matched_reg, m_matched_next;
    logic [5:0]        m_match_slot_reg, m_match_slot_next;

    logic              accept;
    logic              wr_en;
    logic              in_range;
    rule_t             wr_rule;
    logic              rd_en;
    rule_t             rd_rule;
    logic              rd_valid;
    logic              hit;
    logic              issue;

    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_rule_index) < 32'(NUM_RULES));
    assign wr_en    = accept && (s_command == CMD_WRITE) && in_range;
    assign issue    = (state_reg == ST_SCAN) && (scan_cnt_reg < CNT_W'(NUM_RULES));
    assign rd_en    = issue;

    always_comb begin
        wr_rule.kind      = s_rule_kind;
        wr_rule.action    = s_rule_action;
        wr_rule.exact     = s_exact;
        wr_rule.len       = s_length;
        wr_rule.len_mask  = netmask(s_length);
        wr_rule.addr      = s_addr;
        wr_rule.addr_wild = s_addr_wild;
        wr_rule.mask      = s_mask;
        wr_rule.mask_wild = s_mask_wild;
    end

    acl_rule_ram u_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_set   (s_rule_valid),
        .wr_addr  (IDX_W'(s_rule_index)),
        .wr_data  (wr_rule),
        .rd_en    (rd_en),
        .rd_addr  (scan_cnt_reg[IDX_W-1:0]),
        .rd_data  (rd_rule),
        .rd_valid (rd_valid)
    );

    acl_match u_match (
        .rule       (rd_rule),
        .rule_valid (rd_valid),
        .q_addr     (q_addr_reg),
        .q_len      (q_len_reg),
        .q_mask     (q_mask_reg),
        .hit        (hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            pipe_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            pipe_vld_reg <= pipe_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_slot_reg    <= pipe_slot_next;
        m_action_reg     <= m_action_next;
        m_matched_reg    <= m_matched_next;
        m_match_slot_reg <= m_match_slot_next;
        if (accept) begin
            q_addr_reg <= s_addr;
            q_len_reg  <= s_length;
            q_mask_reg <= netmask(s_length);
        end
    end

    always_comb begin
        state_next        = state_reg;
        scan_cnt_next     = scan_cnt_reg;
        pipe_vld_next     = 1'b0;
        pipe_slot_next    = scan_cnt_reg[IDX_W-1:0];
        m_valid_next      = m_valid_reg;
        m_action_next     = m_action_reg;
        m_matched_next    = m_matched_reg;
        m_match_slot_next = m_match_slot_reg;
        s_ready           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                scan_cnt_next = '0;
                if (s_valid) begin
                    if (s_command == CMD_WRITE) begin
                        m_valid_next      = 1'b1;
                        m_action_next     = ACT_DENY;
                        m_matched_next    = 1'b0;
                        m_match_slot_next = 6'd0;
                        state_next        = ST_RESP;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read slot n while comparing slot n-1
                if (issue) begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    pipe_vld_next = 1'b1;
                end
                if (pipe_vld_reg && hit) begin
                    m_valid_next      = 1'b1;
                    m_action_next     = rd_rule.action;
                    m_matched_next    = 1'b1;
                    m_match_slot_next = 6'(pipe_slot_reg);
                    pipe_vld_next     = 1'b0;
                    state_next        = ST_RESP;
                end else if (!issue && !pipe_vld_reg) begin
                    m_valid_next      = 1'b1;
                    m_action_next     = ACT_DENY;
                    m_matched_next    = 1'b0;
                    m_match_slot_next = 6'd0;
                    state_next        = ST_RESP;
                end
            end
            ST_RESP: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_action     = m_action_reg;
    assign m_matched    = m_matched_reg;
    assign m_match_slot = m_match_slot_reg;

    a_resp_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    a_scan_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !m_valid)
        else $error("result shown during a scan");

    a_write_answers: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_command == CMD_WRITE)) |=>
            (m_valid && !m_matched && (m_action == ACT_DENY) && (m_match_slot == 6'd0)))
        else $error("write transfer did not answer deny next cycle");

    a_miss_is_deny: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_matched) |-> ((m_action == ACT_DENY) && (m_match_slot == 6'd0)))
        else $error("unmatched result is not deny at slot 0");

    a_scan_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= CNT_W'(NUM_RULES)))
        else $error("scan counter ran past the table");

endmodule
